// ===== sv/stiff_string_fdtd_step_assert.svh =====
// Assertion macros shared by the string step block.
`ifndef STIFF_STRING_FDTD_STEP_ASSERT_SVH
`define STIFF_STRING_FDTD_STEP_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked while out of reset.
`define SSFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define SSFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SSFD_ASSERT(label, prop, msg)
`define SSFD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== sv/ssfd_pkg.sv =====
package ssfd_pkg;

  localparam int MAX_POINTS = 256;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int SAMPLE_W   = 32;
  localparam int COEF_W     = 32;
  localparam int FRAC_BITS  = 28;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int SUM_W      = PROD_W + 3;
  localparam int POS_W      = 16;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int MIN_N      = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_CENTER      = 3'd0,
    REG_COEF_NEAR        = 3'd1,
    REG_COEF_FAR         = 3'd2,
    REG_COEF_PREV_CENTER = 3'd3,
    REG_COEF_PREV_NEAR   = 3'd4,
    REG_COEF_EDGE_CENTER = 3'd5,
    REG_POINT_COUNT      = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    CMD_STEP   = 1'b0,
    CMD_EXCITE = 1'b1
  } item_cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXCITE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DELIVER
  } ctrl_state_t;

  typedef struct packed {
    logic              clear_we;
    logic [ADDR_W-1:0] clear_addr;
    logic              latch;
    logic              start;
    logic              excite_we;
    logic              issue;
    logic [ADDR_W:0]   issue_k;
    logic              load_out;
    logic              rotate;
  } dp_cmd_t;

  typedef struct packed {
    logic              busy;
    logic [ADDR_W-1:0] n;
  } dp_stat_t;

endpackage

// ===== sv/ssfd_in_if.sv =====
interface ssfd_in_if;
  import ssfd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [POS_W-1:0]           output_pos;
  logic [ADDR_W-1:0]          point_index;
  logic signed [SAMPLE_W-1:0] point_value;
  logic                       strike;

  modport source (output valid, command, output_pos, point_index, point_value, strike,
                  input ready);
  modport sink (input valid, command, output_pos, point_index, point_value, strike,
                output ready);
endinterface

// ===== sv/ssfd_out_if.sv =====
interface ssfd_out_if;
  import ssfd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

// ===== sv/ssfd_ram.sv =====
module ssfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/ssfd_ctrl.sv =====
module ssfd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_command,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  ssfd_pkg::dp_stat_t stat,
  output ssfd_pkg::dp_cmd_t  cmd
);
  import ssfd_pkg::*;

  ctrl_state_t       state, state_next;
  logic [ADDR_W-1:0] clear_cnt, clear_cnt_next;
  logic [ADDR_W:0]   k, k_next;
  logic              accept;
  logic              out_free;
  logic [ADDR_W:0]   k_last;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  // Two points past N so that the far end point also reaches the write stage.
  assign k_last   = {1'b0, stat.n} + (ADDR_W+1)'(2);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clear_cnt == ADDR_W'(MAX_POINTS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_next = (in_command == CMD_EXCITE) ? ST_EXCITE : ST_ISSUE;
      end
      ST_EXCITE:  state_next = ST_IDLE;
      ST_ISSUE: begin
        if (k == k_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.busy) state_next = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    clear_cnt_next = clear_cnt;
    k_next         = k;
    cmd.clear_addr = clear_cnt;
    cmd.issue_k    = k;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_we   = 1'b1;
        clear_cnt_next = clear_cnt + ADDR_W'(1);
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = accept;
        cmd.start = accept && (in_command == CMD_STEP);
        k_next    = '0;
      end
      ST_EXCITE: cmd.excite_we = 1'b1;
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        k_next    = k + (ADDR_W+1)'(1);
      end
      ST_DRAIN: ;
      ST_DELIVER: begin
        cmd.load_out = out_free;
        cmd.rotate   = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clear_cnt <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clear_cnt <= clear_cnt_next;
      k         <= k_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// ===== sv/ssfd_dp.sv =====
module ssfd_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ssfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ssfd_pkg::CFG_W-1:0]           cfg_data,
  input  logic [ssfd_pkg::POS_W-1:0]           output_pos,
  input  logic [ssfd_pkg::ADDR_W-1:0]          point_index,
  input  logic signed [ssfd_pkg::SAMPLE_W-1:0] point_value,
  input  logic                                 strike,
  input  ssfd_pkg::dp_cmd_t                    cmd,
  output ssfd_pkg::dp_stat_t                   stat,
  output logic signed [ssfd_pkg::SAMPLE_W-1:0] sample
);
  import ssfd_pkg::*;

  localparam int NBANK = 3;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (SAMPLE_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) <<< (SAMPLE_W - 1));

  // Configuration registers.
  logic signed [COEF_W-1:0] c_center, c_near, c_far, c_pcenter, c_pnear, c_edge;
  logic [ADDR_W-1:0]        point_count;
  logic [ADDR_W-1:0]        n;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_center    <= '0;
      c_near      <= '0;
      c_far       <= '0;
      c_pcenter   <= '0;
      c_pnear     <= '0;
      c_edge      <= '0;
      point_count <= ADDR_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_CENTER:      c_center    <= cfg_data;
        REG_COEF_NEAR:        c_near      <= cfg_data;
        REG_COEF_FAR:         c_far       <= cfg_data;
        REG_COEF_PREV_CENTER: c_pcenter   <= cfg_data;
        REG_COEF_PREV_NEAR:   c_pnear     <= cfg_data;
        REG_COEF_EDGE_CENTER: c_edge      <= cfg_data;
        REG_POINT_COUNT:      point_count <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign n = (point_count < ADDR_W'(MIN_N)) ? ADDR_W'(MIN_N) : point_count;

  // Latched item.
  logic [ADDR_W-1:0]          ex_idx, pick_idx;
  logic signed [SAMPLE_W-1:0] ex_val;
  logic                       ex_strike;
  logic [POS_W+ADDR_W:0]      pos_prod;
  logic [ADDR_W:0]            pos_idx;

  assign pos_prod = (POS_W+ADDR_W+1)'(output_pos) * (POS_W+ADDR_W+1)'(n)
                  + (POS_W+ADDR_W+1)'(1 << (POS_W - 1));
  assign pos_idx  = pos_prod[POS_W+ADDR_W:POS_W];

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ex_idx    <= point_index;
      ex_val    <= point_value;
      ex_strike <= strike;
      pick_idx  <= (pos_idx > {1'b0, n}) ? n : pos_idx[ADDR_W-1:0];
    end
  end

  // Bank rotation: new bank is rot, current rot+1, previous rot+2 (mod 3).
  logic [1:0] rot, cur_sel, prv_sel;
  always_ff @(posedge clk) begin
    if (rst) begin
      rot <= 2'd0;
    end else if (cmd.rotate) begin
      rot <= (rot == 2'd0) ? 2'd2 : rot - 2'd1;
    end
  end
  assign cur_sel = (rot == 2'd2) ? 2'd0 : rot + 2'd1;
  assign prv_sel = (rot == 2'd0) ? 2'd2 : rot - 2'd1;

  // Banks.
  logic                    bwe   [NBANK];
  logic [ADDR_W-1:0]       bwaddr[NBANK];
  logic [SAMPLE_W-1:0]     bwdata[NBANK];
  logic [SAMPLE_W-1:0]     brdata[NBANK];
  logic                    ex_ok;
  logic                    f_vld;
  logic [ADDR_W-1:0]       f_l;
  logic signed [SUM_W-1:0] f_sum, f_shift;
  logic [SAMPLE_W-1:0]     new_val;
  logic [SAMPLE_W-1:0]     wb_val;

  assign ex_ok = (ex_idx >= ADDR_W'(1)) && (ex_idx <= n - ADDR_W'(2));

  always_comb begin
    for (int b = 0; b < NBANK; b++) begin
      priority if (cmd.clear_we) begin
        bwe[b]    = 1'b1;
        bwaddr[b] = cmd.clear_addr;
        bwdata[b] = '0;
      end else if (cmd.excite_we) begin
        bwe[b]    = ex_ok && ((2'(b) == prv_sel) || ((2'(b) == cur_sel) && !ex_strike));
        bwaddr[b] = ex_idx;
        bwdata[b] = ex_val;
      end else begin
        bwe[b]    = f_vld && (2'(b) == rot);
        bwaddr[b] = f_l;
        bwdata[b] = wb_val;
      end
    end
  end

  for (genvar g = 0; g < NBANK; g++) begin : g_bank
    ssfd_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_POINTS)) u_ram (
      .clk   (clk),
      .we    (bwe[g]),
      .waddr (bwaddr[g]),
      .wdata (bwdata[g]),
      .raddr (cmd.issue_k[ADDR_W-1:0]),
      .rdata (brdata[g])
    );
  end

  // Stage A: read data returns; points outside 1..N-1 read as zero.
  logic                       a_vld;
  logic [ADDR_W:0]            a_k;
  logic                       a_zero;
  logic signed [SAMPLE_W-1:0] cur_v, prv_v;

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else     a_vld <= cmd.issue;
    a_k <= cmd.issue_k;
  end

  assign a_zero = (a_k == '0) || (a_k >= {1'b0, n});
  assign cur_v  = a_zero ? '0 : brdata[cur_sel];
  assign prv_v  = a_zero ? '0 : brdata[prv_sel];

  // Stage B: sliding windows, cw[j] = cur[k-4+j], pw[j] = prv[k-3+j].
  logic signed [SAMPLE_W-1:0] cw[5];
  logic signed [SAMPLE_W-1:0] pw[4];
  logic                       b_vld;
  logic [ADDR_W-1:0]          b_l;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int j = 0; j < 5; j++) cw[j] <= '0;
      for (int j = 0; j < 4; j++) pw[j] <= '0;
    end else if (a_vld) begin
      for (int j = 0; j < 4; j++) cw[j] <= cw[j+1];
      for (int j = 0; j < 3; j++) pw[j] <= pw[j+1];
      cw[4] <= cur_v;
      pw[3] <= prv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else     b_vld <= a_vld && (a_k >= (ADDR_W+1)'(3));
    b_l <= a_k[ADDR_W-1:0] - ADDR_W'(2);
  end

  // Stage C: eight products.
  logic signed [COEF_W-1:0] cc;
  logic signed [PROD_W-1:0] p[8];
  logic                     c_vld;
  logic [ADDR_W-1:0]        c_l;

  assign cc = ((b_l == ADDR_W'(1)) || (b_l == n - ADDR_W'(1))) ? c_edge : c_center;

  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else     c_vld <= b_vld;
    c_l  <= b_l;
    p[0] <= cc * cw[2];
    p[1] <= c_near * cw[1];
    p[2] <= c_near * cw[3];
    p[3] <= c_far * cw[0];
    p[4] <= c_far * cw[4];
    p[5] <= c_pcenter * pw[1];
    p[6] <= c_pnear * pw[0];
    p[7] <= c_pnear * pw[2];
  end

  // Stages D, E, F: adder tree, rounding half added in the last stage.
  logic signed [PROD_W:0]   d[4];
  logic signed [PROD_W+1:0] e[2];
  logic                     d_vld, e_vld;
  logic [ADDR_W-1:0]        d_l, e_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
      e_vld <= 1'b0;
      f_vld <= 1'b0;
    end else begin
      d_vld <= c_vld;
      e_vld <= d_vld;
      f_vld <= e_vld;
    end
    for (int j = 0; j < 4; j++) d[j] <= (PROD_W+1)'(p[2*j]) + (PROD_W+1)'(p[2*j+1]);
    for (int j = 0; j < 2; j++) e[j] <= (PROD_W+2)'(d[2*j]) + (PROD_W+2)'(d[2*j+1]);
    f_sum <= SUM_W'(e[0]) + SUM_W'(e[1]) + ROUND_HALF;
    d_l <= c_l;
    e_l <= d_l;
    f_l <= e_l;
  end

  // Scale down and saturate; written back to the new bank. The far end point
  // passes through the pipeline last and is written with zero.
  assign f_shift = f_sum >>> FRAC_BITS;
  always_comb begin
    priority if (f_shift > SAT_HI) new_val = SAT_HI[SAMPLE_W-1:0];
    else if (f_shift < SAT_LO)     new_val = SAT_LO[SAMPLE_W-1:0];
    else                           new_val = f_shift[SAMPLE_W-1:0];
  end
  assign wb_val = (f_l == n) ? '0 : new_val;

  // Listening point capture; the end points stay zero.
  logic signed [SAMPLE_W-1:0] pick;
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pick <= '0;
    end else if (f_vld && (f_l == pick_idx)) begin
      pick <= wb_val;
    end
    if (cmd.load_out) begin
      sample <= pick;
    end
  end

  assign stat.busy = a_vld || b_vld || c_vld || d_vld || e_vld || f_vld;
  assign stat.n    = n;
endmodule

// ===== sv/stiff_string_fdtd_step.sv =====
// Damped stiff string time step in signed Q3.28. A step word (command 0)
// recomputes grid points 1..N-1 from the current and previous banks, returns
// one sample word taken at point round(output_pos*N/2^16), and rotates the three banks.
// An excite word (command 1) writes one point in 1..N-2 and returns nothing.
// A step reads each bank through its single read port, which delivers one
// grid point per cycle into the stencil window, followed by the multiply and
// adder tree pipeline. A new word is accepted as soon as the previous one is
// finished, even while a result still waits at the output. After reset all
// 256 addresses of each bank are cleared, and no word is accepted while this
// clearing runs; configuration writes are taken at any time.
`include "stiff_string_fdtd_step_assert.svh"

module stiff_string_fdtd_step (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ssfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssfd_pkg::CFG_W-1:0]     cfg_data,
  ssfd_in_if.sink                        in_ch,
  ssfd_out_if.source                     out_ch
);
  import ssfd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller sequences clearing, excitation, point issue and delivery.
  ssfd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .stat       (stat),
    .cmd        (cmd)
  );

  // The datapath holds the banks, the stencil window and the arithmetic.
  ssfd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .output_pos  (in_ch.output_pos),
    .point_index (in_ch.point_index),
    .point_value (in_ch.point_value),
    .strike      (in_ch.strike),
    .cmd         (cmd),
    .stat        (stat),
    .sample      (out_ch.sample)
  );

  // Only one of clearing, excitation, point issue and result loading is commanded at a time.
  `SSFD_ASSERT(a_one_activity, $onehot0({cmd.clear_we, cmd.excite_we, cmd.issue, cmd.load_out}), "overlapping datapath activities")
  // No word is taken while points are still in flight.
  `SSFD_ASSERT(a_idle_when_ready, in_ch.ready |-> !stat.busy, "word accepted with pipeline busy")
  // A loaded result is presented in the next cycle.
  `SSFD_ASSERT(a_load_shows, cmd.load_out |=> out_ch.valid, "loaded result not valid")
endmodule
